FILE: sv/hgpc_pkg.sv
// Shared constants and stage payload types for the HSV to GRB pixel converter.
// No dependencies; every module of the block imports this package.
package hgpc_pkg;

    // Hue scale and sector geometry.
    localparam logic [7:0] HUE_TOP      = 8'd179;
    localparam int         SECTOR       = 30;
    localparam int         SECTOR_COUNT = 6;

    // Reciprocal of the sector width, scaled by two to the RECIP_SHIFT.
    localparam int          RECIP_SHIFT = 20;
    localparam logic [15:0] RECIP30     = 16'd34953;

    // Payload after the front stages: sector, offset in sector, value, minimum.
    typedef struct packed {
        logic [2:0] sector;
        logic [4:0] offset;
        logic [7:0] value;
        logic [7:0] lo;
    } t_front;

    // Payload after the ramp stages.
    typedef struct packed {
        logic [2:0] sector;
        logic [7:0] value;
        logic [7:0] lo;
        logic [7:0] ramp;
    } t_ramp;

endpackage

FILE: sv/hgpc_front.sv
// Front two pipeline stages: hue clamp, sector split, and the channel minimum.
// Depends on hgpc_pkg for the payload type and hue constants.
module hgpc_front
    import hgpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_hue,
    input  logic [7:0]  i_saturation,
    input  logic [7:0]  i_brightness,
    output logic        o_valid,
    input  logic        i_ready,
    output t_front      o_data
);

    logic        r_a_valid;
    logic [2:0]  r_a_sector;
    logic [4:0]  r_a_offset;
    logic [7:0]  r_a_value;
    logic [15:0] r_a_prod;
    logic        r_b_valid;
    t_front      r_b_data;

    logic        a_ready;
    logic        b_ready;
    logic [7:0]  hue_sat;
    logic [7:0]  hue_base;
    logic [2:0]  n_sector;
    logic [15:0] lo_sum;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Saturate the hue to the last sector, then find its sector by compares.
    always_comb begin
        hue_sat = (i_hue > HUE_TOP) ? HUE_TOP : i_hue;
        if (hue_sat >= 8'(5 * SECTOR)) begin
            n_sector = 3'd5;
            hue_base = 8'(5 * SECTOR);
        end else if (hue_sat >= 8'(4 * SECTOR)) begin
            n_sector = 3'd4;
            hue_base = 8'(4 * SECTOR);
        end else if (hue_sat >= 8'(3 * SECTOR)) begin
            n_sector = 3'd3;
            hue_base = 8'(3 * SECTOR);
        end else if (hue_sat >= 8'(2 * SECTOR)) begin
            n_sector = 3'd2;
            hue_base = 8'(2 * SECTOR);
        end else if (hue_sat >= 8'(SECTOR)) begin
            n_sector = 3'd1;
            hue_base = 8'(SECTOR);
        end else begin
            n_sector = 3'd0;
            hue_base = 8'd0;
        end
    end

    // The product divided by 255, exact for every product of two 8-bit values.
    assign lo_sum = r_a_prod + {8'd0, r_a_prod[15:8]} + 16'd1;

    // Stage A: sector split and (255 - saturation) * value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready && i_valid) begin
            r_a_sector <= n_sector;
            r_a_offset <= 5'(hue_sat - hue_base);
            r_a_value  <= i_brightness;
            r_a_prod   <= {8'd0, ~i_saturation} * {8'd0, i_brightness};
        end
    end

    // Stage B: the minimum channel level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_data.sector <= r_a_sector;
            r_b_data.offset <= r_a_offset;
            r_b_data.value  <= r_a_value;
            r_b_data.lo     <= lo_sum[15:8];
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

FILE: sv/hgpc_ramp.sv
// Ramp pipeline stages: (value - minimum) * offset, then division by the sector width.
// Depends on hgpc_pkg for payload types and the reciprocal constant.
module hgpc_ramp
    import hgpc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_ramp  o_data
);

    logic        r_c_valid;
    logic [2:0]  r_c_sector;
    logic [7:0]  r_c_value;
    logic [7:0]  r_c_lo;
    logic [12:0] r_c_prod;
    logic        r_d_valid;
    t_ramp       r_d_data;

    logic        c_ready;
    logic        d_ready;
    logic [7:0]  span;
    logic [27:0] scaled;

    assign d_ready = !r_d_valid || i_ready;
    assign c_ready = !r_c_valid || d_ready;
    assign o_ready = c_ready;

    // The span never goes negative since the minimum is at most the value.
    assign span   = i_data.value - i_data.lo;
    // Product stays below 7400, so the scaled reciprocal fits 28 bits exactly.
    assign scaled = 28'({15'd0, r_c_prod} * {12'd0, RECIP30});

    // Stage C: span times offset within the sector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_ready) begin
            r_c_valid <= i_valid;
        end
        if (c_ready && i_valid) begin
            r_c_sector <= i_data.sector;
            r_c_value  <= i_data.value;
            r_c_lo     <= i_data.lo;
            r_c_prod   <= {5'd0, span} * {8'd0, i_data.offset};
        end
    end

    // Stage D: truncating division by the sector width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (d_ready) begin
            r_d_valid <= r_c_valid;
        end
        if (d_ready && r_c_valid) begin
            r_d_data.sector <= r_c_sector;
            r_d_data.value  <= r_c_value;
            r_d_data.lo     <= r_c_lo;
            r_d_data.ramp   <= scaled[RECIP_SHIFT +: 8];
        end
    end

    assign o_valid = r_d_valid;
    assign o_data  = r_d_data;

endmodule

FILE: sv/hsv_to_grb_pixel_convert.sv
// Top level of the HSV to GRB pixel converter: front, ramp and channel select.
// Depends on hgpc_pkg, hgpc_front and hgpc_ramp.
//
// Usage:
//   The slave channel takes one HSV pixel per word: hue (0..179, larger hue
//   is treated as 179), saturation and brightness, eight bits each. The
//   master channel gives one word per pixel with the channels in LED strip
//   order: green, red, blue.
//   Throughput is one pixel per clock while the master side takes words;
//   the five register stages (sector split and minimum product, divide by
//   255, ramp product, divide by 30, channel select) each take a new word
//   every cycle unless held by a stall.
//   Every stage carries its own valid bit and advances whenever it is empty
//   or the next stage moves, so bubbles close up and a stall on the master
//   side holds the words in place without loss or repetition; the slave
//   side stops only once all stages are full.
//   Reset clears the valid bits, so no output word is shown after reset.
module hsv_to_grb_pixel_convert
    import hgpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // hue [7:0], saturation [15:8], brightness [23:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata    // green [7:0], red [15:8], blue [23:16]
);

    logic        front_valid;
    logic        front_ready;
    t_front      front_data;
    logic        ramp_valid;
    logic        ramp_ready;
    t_ramp       ramp_data;

    logic        r_valid;
    logic [7:0]  r_green;
    logic [7:0]  r_red;
    logic [7:0]  r_blue;
    logic [7:0]  n_green;
    logic [7:0]  n_red;
    logic [7:0]  n_blue;
    logic [7:0]  rise;
    logic [7:0]  fall;

    hgpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_hue        (i_s_tdata[7:0]),
        .i_saturation (i_s_tdata[15:8]),
        .i_brightness (i_s_tdata[23:16]),
        .o_valid      (front_valid),
        .i_ready      (front_ready),
        .o_data       (front_data)
    );

    hgpc_ramp u_ramp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (ramp_valid),
        .i_ready (ramp_ready),
        .o_data  (ramp_data)
    );

    assign ramp_ready = !r_valid || i_m_tready;

    // Rising and falling channel levels within the sector.
    assign rise = ramp_data.lo + ramp_data.ramp;
    assign fall = ramp_data.value - ramp_data.ramp;

    // Pick each channel by sector.
    always_comb begin
        unique case (ramp_data.sector)
            3'd0: begin
                n_red = ramp_data.value; n_green = rise;            n_blue = ramp_data.lo;
            end
            3'd1: begin
                n_red = fall;            n_green = ramp_data.value; n_blue = ramp_data.lo;
            end
            3'd2: begin
                n_red = ramp_data.lo;    n_green = ramp_data.value; n_blue = rise;
            end
            3'd3: begin
                n_red = ramp_data.lo;    n_green = fall;            n_blue = ramp_data.value;
            end
            3'd4: begin
                n_red = rise;            n_green = ramp_data.lo;    n_blue = ramp_data.value;
            end
            default: begin
                n_red = ramp_data.value; n_green = ramp_data.lo;    n_blue = fall;
            end
        endcase
    end

    // Output register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ramp_ready) begin
            r_valid <= ramp_valid;
        end
        if (ramp_ready && ramp_valid) begin
            r_green <= n_green;
            r_red   <= n_red;
            r_blue  <= n_blue;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_blue, r_red, r_green};

endmodule
